>>> hdl/plmm_pkg.sv
package plmm_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam int          MATCH_IDX_BITS = 12;
    localparam int          OCT_BITS       = 4;
    localparam logic [3:0]  OCT_MAX        = 4'd15;

    typedef struct packed {
        logic                      found;
        logic [MATCH_IDX_BITS-1:0] match_index;
        logic [OCT_BITS-1:0]       new_octave;
    } t_result;

endpackage

>>> hdl/plmm_ram.sv
module plmm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/plmm_seq.sv
module plmm_seq
    import plmm_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [COORD_BITS-1:0]         i_point_x,
    input  logic [COORD_BITS-1:0]         i_point_y,
    input  logic [OCT_BITS-1:0]           i_query_octave,
    output logic                          o_we,
    output logic [$clog2(MAX_POINTS)-1:0] o_waddr,
    output logic [2*COORD_BITS-1:0]       o_wdata,
    output logic [$clog2(MAX_POINTS)-1:0] o_raddr,
    input  logic [2*COORD_BITS-1:0]       i_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output t_result                       o_res
);

    localparam int CW = COORD_BITS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        P_SKIP_EVEN = 4'b0001,
        P_SKIP_ODD  = 4'b0010,
        P_SCAN_EVEN = 4'b0100,
        P_SCAN_ODD  = 4'b1000
    } t_phase;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [NW-1:0]   r_cur, n_cur;
    logic [NW-1:0]   r_even, n_even;
    logic [NW-1:0]   r_odd, n_odd;
    logic [NW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_last_row, n_last_row;
    logic            r_last_valid, n_last_valid;
    logic [CW-1:0]   r_qx, n_qx;
    logic [CW-1:0]   r_qy, n_qy;
    logic [3:0]      r_qoct, n_qoct;
    t_result         r_res, n_res;

    logic [CW-1:0]   rd_x;
    logic [CW-1:0]   rd_y;
    logic            below_even;
    logic            upto_odd;
    logic            same_row;
    logic            left_of;
    logic            same_col;
    logic            cont;
    logic            hit;
    logic            ending;
    logic            hit_now;
    logic            accept;
    logic [NW+MATCH_IDX_BITS-1:0] cur_ext;
    logic [3:0]      oct_inc;

    assign rd_x       = i_rdata[CW-1:0];
    assign rd_y       = i_rdata[2*CW-1:CW];
    assign below_even = {1'b0, rd_y} < {r_qy, 1'b0};
    assign upto_odd   = {1'b0, rd_y} <= {r_qy, 1'b0};
    assign same_row   = {1'b0, rd_y[CW-1:1]} == r_qy;
    assign left_of    = {1'b0, rd_x[CW-1:1]} < r_qx;
    assign same_col   = {1'b0, rd_x[CW-1:1]} == r_qx;
    assign hit        = same_row && same_col;
    assign cur_ext    = {{MATCH_IDX_BITS{1'b0}}, r_cur};
    assign oct_inc    = (r_qoct == OCT_MAX) ? OCT_MAX : r_qoct + 4'd1;

    always_comb begin
        unique case (r_phase)
            P_SKIP_EVEN: cont = below_even;
            P_SKIP_ODD:  cont = upto_odd;
            P_SCAN_EVEN: cont = same_row && left_of;
            P_SCAN_ODD:  cont = same_row && left_of;
            default:     cont = 1'b0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_waddr     = r_count[AW-1:0];
    assign o_wdata     = {i_point_y, i_point_x};
    assign o_raddr     = r_cur[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cur        = r_cur;
        n_even       = r_even;
        n_odd        = r_odd;
        n_count      = r_count;
        n_last_row   = r_last_row;
        n_last_valid = r_last_valid;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_qoct       = r_qoct;
        n_res        = r_res;
        o_we         = 1'b0;
        ending       = 1'b0;
        hit_now      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_LOAD: begin
                            if (r_count < NW'(MAX_POINTS)) begin
                                o_we    = 1'b1;
                                n_count = r_count + NW'(1);
                            end
                        end
                        MODE_QUERY: begin
                            n_qx    = i_point_x;
                            n_qy    = i_point_y;
                            n_qoct  = i_query_octave;
                            n_state = S_STEP;
                            if (!r_last_valid || r_last_row != i_point_y) begin
                                n_phase = P_SKIP_EVEN;
                                n_cur   = r_odd;
                            end else begin
                                n_phase = P_SCAN_EVEN;
                                n_cur   = r_even;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count      = '0;
                            n_even       = '0;
                            n_odd        = '0;
                            n_last_row   = '0;
                            n_last_valid = 1'b0;
                        end
                        MODE_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (r_cur < r_count) begin
                    n_state = S_EVAL;
                end else begin
                    ending = 1'b1;
                end
            end
            S_EVAL: begin
                if (cont) begin
                    n_cur   = r_cur + NW'(1);
                    n_state = S_STEP;
                end else begin
                    ending  = 1'b1;
                    hit_now = hit;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ending) begin
            unique case (r_phase)
                P_SKIP_EVEN: begin
                    n_even  = r_cur;
                    n_phase = P_SKIP_ODD;
                    n_state = S_STEP;
                end
                P_SKIP_ODD: begin
                    n_odd        = r_cur;
                    n_last_row   = r_qy;
                    n_last_valid = 1'b1;
                    n_phase      = P_SCAN_EVEN;
                    n_cur        = r_even;
                    n_state      = S_STEP;
                end
                P_SCAN_EVEN: begin
                    n_even = r_cur;
                    if (hit_now) begin
                        n_res.found       = 1'b1;
                        n_res.match_index = cur_ext[MATCH_IDX_BITS-1:0];
                        n_res.new_octave  = oct_inc;
                        n_state           = S_DONE;
                    end else begin
                        n_phase = P_SCAN_ODD;
                        n_cur   = r_odd;
                        n_state = S_STEP;
                    end
                end
                P_SCAN_ODD: begin
                    n_odd             = r_cur;
                    n_res.found       = hit_now;
                    n_res.match_index = hit_now ? cur_ext[MATCH_IDX_BITS-1:0] : '0;
                    n_res.new_octave  = hit_now ? oct_inc : '0;
                    n_state           = S_DONE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= P_SKIP_EVEN;
            r_cur        <= '0;
            r_even       <= '0;
            r_odd        <= '0;
            r_count      <= '0;
            r_last_row   <= '0;
            r_last_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_cur        <= n_cur;
            r_even       <= n_even;
            r_odd        <= n_odd;
            r_count      <= n_count;
            r_last_row   <= n_last_row;
            r_last_valid <= n_last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx   <= n_qx;
        r_qy   <= n_qy;
        r_qoct <= n_qoct;
        r_res  <= n_res;
    end

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_even <= r_count) && (r_odd <= r_count))
        else $error("cursor beyond point count");

    a_eval_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_cur < r_count))
        else $error("evaluating an unwritten entry");

    a_advance_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && cont) |=> (r_cur == $past(r_cur) + NW'(1)))
        else $error("cursor did not advance by one");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> (o_res.match_index == '0 && o_res.new_octave == '0))
        else $error("miss result carries nonzero fields");

endmodule

>>> hdl/pyramid_level_match_merge.sv
// Merge-join of coarse keypoints against a raster-sorted fine keypoint list.
// Input stream: s_axis_tuser carries the mode (load, query, clear), s_axis_tdata
// carries point_x, point_y and query_octave. A load appends a fine point
// (dropped once the list is full); a clear empties the list and cursors.
// Neither gives an output word.
// Each query gives exactly one output word: m_axis_tuser is found,
// m_axis_tdata carries match_index and new_octave.
// A query walks one to four cursor phases. The point store has a single read
// port with a registered output; each fine point that a cursor passes over
// costs one read of it, through a step state and then an evaluate state.
// After the result enters the output register, input is accepted again in
// the next cycle.
// s_axis_tready is low while a query is at work and while its result waits to
// enter the output register. A finished result waits in that register, so input
// runs on while the receiver stalls, until a second result is finished behind it.
// Synchronous reset empties the list, zeroes both cursors and forgets the last
// query row; the store contents are not cleared.
module pyramid_level_match_merge
    import plmm_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // point_x, point_y, query_octave, zero pad
    input  logic [((2*COORD_BITS+OCT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]                              s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // match_index, new_octave
    output logic [MATCH_IDX_BITS+OCT_BITS-1:0]      m_axis_tdata,
    // found
    output logic                                    m_axis_tuser
);

    localparam int CW = COORD_BITS;
    localparam int AW = $clog2(MAX_POINTS);

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [2*CW-1:0]      wdata;
    logic [AW-1:0]        raddr;
    logic [2*CW-1:0]      rdata;
    logic                 res_valid;
    logic                 res_ready;
    t_result              res;

    logic                 r_out_valid;
    t_result              r_out;

    plmm_ram #(
        .WIDTH (2*CW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    plmm_seq #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_mode         (s_axis_tuser),
        .i_point_x      (s_axis_tdata[CW-1:0]),
        .i_point_y      (s_axis_tdata[2*CW-1:CW]),
        .i_query_octave (s_axis_tdata[2*CW+OCT_BITS-1:2*CW]),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.new_octave, r_out.match_index};
    assign m_axis_tuser  = r_out.found;

endmodule
